// File: hdl/tga_rle_pkg.sv
package tga_rle_pkg;

	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 32;
	localparam int CFG_W    = 32;
	localparam int Q_DEPTH  = 2;
	localparam int Q_AW     = $clog2(Q_DEPTH);
	localparam int Q_CW     = $clog2(Q_DEPTH + 1);

	localparam logic       REG_ALPHA_PRESENT = 1'b0;
	localparam logic       REG_IMAGE_PIXELS  = 1'b1;

	localparam logic [BYTE_W-1:0] RAW_MAX_CODE  = 8'd127;
	localparam logic [1:0]        SLOT_RED      = 2'd2;
	localparam logic [1:0]        SLOT_ALPHA    = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] byte0;
		logic [BYTE_W-1:0] byte1;
		logic [BYTE_W-1:0] byte2;
		logic [BYTE_W-1:0] byte3;
		logic              keep_alpha;
		logic [BYTE_W-1:0] run;
		logic              last;
	} pix_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: hdl/tga_rle_front.sv
module tga_rle_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [tga_rle_pkg::CFG_W-1:0] cfg_data,
	input  logic                          byte_valid,
	input  logic [tga_rle_pkg::BYTE_W-1:0] byte_data,
	output tga_rle_pkg::pix_rec_t          rec,
	output logic                          rec_valid
);
	import tga_rle_pkg::*;

	logic                alpha_present_q;
	logic [COUNT_W-1:0]  image_pixels_q;
	logic                expect_q;
	logic                repeat_q;
	logic [BYTE_W-1:0]   raw_left_q;
	logic [1:0]          slot_q;
	logic [BYTE_W-1:0]   pb_q [3];
	logic [COUNT_W-1:0]  pixels_left_q;

	logic [COUNT_W-1:0]  pl_base;
	logic [BYTE_W-1:0]   hdr_n;
	logic [BYTE_W-1:0]   hdr_clip;
	logic                done;
	logic [BYTE_W-1:0]   run_raw;
	logic [BYTE_W-1:0]   run_clip;
	logic [COUNT_W-1:0]  pl_next;
	logic [BYTE_W-1:0]   raw_dec;

	always_comb begin
		if (pixels_left_q != '0) begin
			pl_base = pixels_left_q;
		end else if (image_pixels_q == '0) begin
			pl_base = COUNT_W'(1);
		end else begin
			pl_base = image_pixels_q;
		end
		if (byte_data[BYTE_W-1]) begin
			hdr_n = byte_data - RAW_MAX_CODE;
		end else begin
			hdr_n = byte_data + BYTE_W'(1);
		end
		if (COUNT_W'(hdr_n) > pl_base) begin
			hdr_clip = pl_base[BYTE_W-1:0];
		end else begin
			hdr_clip = hdr_n;
		end
		done = (slot_q == SLOT_ALPHA) || (slot_q == SLOT_RED && !alpha_present_q);
		if (!repeat_q || raw_left_q == '0) begin
			run_raw = BYTE_W'(1);
		end else begin
			run_raw = raw_left_q;
		end
		if (COUNT_W'(run_raw) > pixels_left_q) begin
			run_clip = pixels_left_q[BYTE_W-1:0];
		end else begin
			run_clip = run_raw;
		end
		pl_next = pixels_left_q - COUNT_W'(run_clip);
		raw_dec = (raw_left_q != '0) ? raw_left_q - BYTE_W'(1) : raw_left_q;
	end

	always_comb begin
		rec_valid       = byte_valid && !expect_q && done;
		rec.byte0       = pb_q[0];
		rec.byte1       = pb_q[1];
		rec.byte2       = (slot_q == SLOT_RED) ? byte_data : pb_q[2];
		rec.byte3       = byte_data;
		rec.keep_alpha  = (slot_q == SLOT_ALPHA) && alpha_present_q;
		rec.run         = run_clip;
		rec.last        = (pl_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_present_q <= 1'b0;
			image_pixels_q  <= COUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA_PRESENT: alpha_present_q <= cfg_data[0];
				REG_IMAGE_PIXELS:  image_pixels_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q      <= 1'b1;
			repeat_q      <= 1'b0;
			raw_left_q    <= '0;
			slot_q        <= '0;
			pixels_left_q <= '0;
		end else if (byte_valid) begin
			if (expect_q) begin
				pixels_left_q <= pl_base;
				repeat_q      <= byte_data[BYTE_W-1];
				raw_left_q    <= hdr_clip;
				slot_q        <= '0;
				expect_q      <= 1'b0;
			end else if (!done) begin
				slot_q <= slot_q + 2'd1;
			end else begin
				slot_q        <= '0;
				pixels_left_q <= pl_next;
				if (repeat_q || pl_next == '0) begin
					raw_left_q <= '0;
					expect_q   <= 1'b1;
				end else begin
					raw_left_q <= raw_dec;
					if (raw_dec == '0) begin
						expect_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !expect_q && slot_q != SLOT_ALPHA) begin
			pb_q[slot_q] <= byte_data;
		end
	end

endmodule

// File: hdl/tga_rle_queue.sv
module tga_rle_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tga_rle_pkg::pix_rec_t push_rec,
	input  logic                  pop,
	output tga_rle_pkg::pix_rec_t pop_rec,
	output tga_rle_pkg::q_stat_t  stat
);
	import tga_rle_pkg::*;

	pix_rec_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_CW-1:0]   count_q;

	always_comb begin
		stat.full  = (count_q == Q_CW'(Q_DEPTH));
		stat.empty = (count_q == '0);
		pop_rec    = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CW'(1);
				2'b01:   count_q <= count_q - Q_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// File: hdl/tga_rle_back.sv
module tga_rle_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rec_avail,
	input  tga_rle_pkg::pix_rec_t          rec,
	output logic                           rec_take,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tga_rle_pkg::BYTE_W-1:0] red,
	output logic [tga_rle_pkg::BYTE_W-1:0] green,
	output logic [tga_rle_pkg::BYTE_W-1:0] blue,
	output logic [tga_rle_pkg::BYTE_W-1:0] alpha,
	output logic [tga_rle_pkg::BYTE_W-1:0] run_length,
	output logic                           image_end
);
	import tga_rle_pkg::*;

	logic valid_q;

	assign rec_take  = rec_avail && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_take) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			red        <= rec.byte2;
			green      <= rec.byte1;
			blue       <= rec.byte0;
			alpha      <= rec.keep_alpha ? rec.byte3 : '0;
			run_length <= rec.run;
			image_end  <= rec.last;
		end
	end

endmodule

// File: hdl/tga_rle_pixel_decoder_unit.sv
// TGA run-length pixel decoder.
// Input channel: in_valid/in_ready with file_byte, one byte of the coded
// image body per transfer. A packet byte opens a raw or a repeat packet;
// pixel bytes follow, three per pixel, or four when alpha_present is set.
// Output channel: out_valid/out_ready with red, green, blue, alpha,
// run_length and image_end, one transfer per decoded pixel. image_end marks
// the pixel that completes image_pixels; the decoder then rearms.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Throughput: one input byte per cycle, sustained, with the receiver ready.
// Path: the parser decodes a pixel as its last byte transfers and writes
// it into the queue at that edge; the output register then loads it from
// the queue once the output register is free.
// Stall: when out_ready is low the output holds, the queue fills, and
// in_ready drops once the queue is full.
// Reset: arst_n clears control state; alpha_present resets to 0 and
// image_pixels to 1; the parser waits for a packet byte.
module tga_rle_pixel_decoder_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tga_rle_pkg::BYTE_W-1:0] file_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tga_rle_pkg::BYTE_W-1:0] red,
	output logic [tga_rle_pkg::BYTE_W-1:0] green,
	output logic [tga_rle_pkg::BYTE_W-1:0] blue,
	output logic [tga_rle_pkg::BYTE_W-1:0] alpha,
	output logic [tga_rle_pkg::BYTE_W-1:0] run_length,
	output logic                           image_end,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [tga_rle_pkg::CFG_W-1:0]  cfg_data
);
	import tga_rle_pkg::*;

	logic     byte_xfer;
	pix_rec_t front_rec;
	logic     front_valid;
	pix_rec_t q_rec;
	q_stat_t  q_stat;
	logic     q_pop;

	assign in_ready  = !q_stat.full;
	assign byte_xfer = in_valid && in_ready;

	tga_rle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_valid (byte_xfer),
		.byte_data  (file_byte),
		.rec        (front_rec),
		.rec_valid  (front_valid)
	);

	tga_rle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_valid),
		.push_rec (front_rec),
		.pop      (q_pop),
		.pop_rec  (q_rec),
		.stat     (q_stat)
	);

	tga_rle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_avail  (!q_stat.empty),
		.rec        (q_rec),
		.rec_take   (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.run_length (run_length),
		.image_end  (image_end)
	);

`ifndef SYNTH
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(front_valid && q_stat.full))
		else $error("queue push while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("queue pop while empty");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("zero run length on output");
`endif

endmodule
